### rtl/core/mhic_pkg.sv
// ----------------------------------------------------------------------------
// mhic_pkg
// shared constants, codes and types of the magnetometer hard-iron calibrator
// ----------------------------------------------------------------------------
package mhic_pkg;

	localparam int unsigned FRAC_BITS_DEF = 8;

	localparam int unsigned RAW_W    = 16;
	localparam int unsigned FIELD_W  = 25;
	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned CYCLES_W = 16;
	localparam int unsigned GATE_W   = 15;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CALIBRATION_CYCLES = 2'd0,
		REG_GATE_LIMIT         = 2'd1
	} cfg_reg_t;

	localparam logic [CYCLES_W-1:0] CAL_CYCLES_RST = 16'd1000;
	localparam logic [GATE_W-1:0]   GATE_LIMIT_RST = 15'd400;
	localparam logic [OFFSET_W-1:0] OFFSET_RST     = '1;
	localparam logic [GAIN_W-1:0]   GAIN_Y_RST     = 16'd219;
	localparam logic [GAIN_W-1:0]   GAIN_Z_RST     = 16'd240;
	localparam logic [GAIN_W-1:0]   GAIN_SAT       = '1;
	localparam int                  EXTREME_RST    = 100;

	// y = (68592 * raw - 102888) / 2^16, x = raw - 8
	localparam int unsigned Y_SCALE_Q16 = 68592;
	localparam int unsigned Y_BIAS_Q16  = 102888;
	localparam int unsigned X_BIAS      = 8;

	// restoring divider: one quotient bit per step, top bit flags saturation
	localparam int unsigned DIV_STEPS  = GAIN_W + 1;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int unsigned GAIN_SHIFT = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_GATE,
		ST_MID,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

### rtl/core/mhic_sample_if.sv
// ----------------------------------------------------------------------------
// mhic_sample_if
// input channel: three raw magnetometer words and a start-calibration flag
// ----------------------------------------------------------------------------
interface mhic_sample_if;
	import mhic_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_first_axis;
	logic signed [RAW_W-1:0] raw_second_axis;
	logic signed [RAW_W-1:0] raw_third_axis;
	logic                    start_calibration;

	modport source (
		output valid, raw_first_axis, raw_second_axis, raw_third_axis, start_calibration,
		input  ready
	);

	modport sink (
		input  valid, raw_first_axis, raw_second_axis, raw_third_axis, start_calibration,
		output ready
	);

endinterface

### rtl/core/mhic_result_if.sv
// ----------------------------------------------------------------------------
// mhic_result_if
// output channel: corrected field, offsets, gains and calibration status
// ----------------------------------------------------------------------------
interface mhic_result_if;
	import mhic_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [FIELD_W-1:0]  field_x;
	logic signed [FIELD_W-1:0]  field_y;
	logic signed [FIELD_W-1:0]  field_z;
	logic signed [OFFSET_W-1:0] offset_x_out;
	logic signed [OFFSET_W-1:0] offset_y_out;
	logic signed [OFFSET_W-1:0] offset_z_out;
	logic [GAIN_W-1:0]          gain_y_out;
	logic [GAIN_W-1:0]          gain_z_out;
	logic                       calibrating;
	logic                       calibration_done;

	modport source (
		output valid, field_x, field_y, field_z, offset_x_out, offset_y_out, offset_z_out,
		       gain_y_out, gain_z_out, calibrating, calibration_done,
		input  ready
	);

	modport sink (
		input  valid, field_x, field_y, field_z, offset_x_out, offset_y_out, offset_z_out,
		       gain_y_out, gain_z_out, calibrating, calibration_done,
		output ready
	);

endinterface

### rtl/core/mhic_cfg_if.sv
// ----------------------------------------------------------------------------
// mhic_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface mhic_cfg_if;
	import mhic_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);

endinterface

### rtl/core/magnetometer_hard_iron_calibrator.sv
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibrator
// min/max midpoint hard-iron calibration with pre-correction of the raw axes
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. An ordinary sample passes through these
// steps in order: the beat is accepted, the y scaling product is rounded and the
// corrected fields formed, the gate and extremes are updated, and the result is
// moved into the output register; then the block is ready for the next sample.
// A sample that completes calibration adds a step to form the midpoints and
// spans, after which the shared restoring divider produces one quotient bit
// per cycle, 17 bits for the y gain and then 17 for the z gain. A result
// waiting in the output register does not block the next sample; only when a
// second result is ready before the first is taken does the block hold.
// Register writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator #(
	parameter int unsigned FRACTION_BITS = mhic_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mhic_sample_if.sink   sample,
	mhic_result_if.source result,
	mhic_cfg_if.sink      cfg
);
	import mhic_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int EB  = 10 + F;
	localparam int VW  = 18 + F;
	localparam int WW  = (VW + 1 > FIELD_W) ? VW + 1 : FIELD_W;
	localparam int PW  = 34;
	localparam int SH  = 16 - F;
	localparam int RW  = EB + GAIN_SHIFT;
	localparam int DW  = EB + GAIN_W;

	localparam logic signed [PW-1:0] Y_SCALE_W = PW'(Y_SCALE_Q16);
	localparam logic signed [PW-1:0] Y_BIAS_W  = PW'(Y_BIAS_Q16);
	localparam logic signed [PW-1:0] HALF_W    = PW'((64'd1 << SH) >> 1);
	localparam logic signed [VW-1:0] X_BIAS_W  = VW'(X_BIAS);

	localparam logic signed [EB-1:0] EXT_HI  = {1'b0, {(EB-1){1'b1}}};
	localparam logic signed [EB-1:0] EXT_LO  = {1'b1, {(EB-1){1'b0}}};
	localparam logic signed [EB-1:0] MAX_RST = EB'(-(EXTREME_RST * (64'sd1 <<< F)));
	localparam logic signed [EB-1:0] MIN_RST = EB'(EXTREME_RST * (64'sd1 <<< F));
	localparam logic signed [EB:0]   MID_RND = (EB+1)'((64'd1 << (F + 1)) - 1);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t state_q, state_d;

	// registers
	logic [CYCLES_W-1:0]        cycles_q;
	logic [GATE_W-1:0]          gate_q;
	logic signed [PW-1:0]       prod_q;
	logic signed [VW-1:0]       v_q [3];
	logic                       start_q;
	logic signed [FIELD_W-1:0]  fld_q [3];
	logic signed [EB-1:0]       max_q [3];
	logic signed [EB-1:0]       min_q [3];
	logic signed [OFFSET_W-1:0] off_q [3];
	logic [GAIN_W-1:0]          gain_y_q;
	logic [GAIN_W-1:0]          gain_z_q;
	logic [CYCLES_W-1:0]        cnt_q;
	logic                       mode_q;
	logic                       done_q;
	logic signed [EB:0]         span_x_q;
	logic signed [EB:0]         span_z_q;
	logic [RW-1:0]              rem_q;
	logic [DW-1:0]              dsh_q;
	logic [DIV_STEPS-1:0]       quo_q;
	logic                       zden_q;
	logic                       sel_q;
	logic [DIV_CNT_W-1:0]       step_q;

	logic                       res_valid_q;
	logic signed [FIELD_W-1:0]  res_fld_q [3];
	logic signed [OFFSET_W-1:0] res_off_q [3];
	logic [GAIN_W-1:0]          res_gain_y_q;
	logic [GAIN_W-1:0]          res_gain_z_q;
	logic                       res_cal_q;
	logic                       res_done_q;

	// combinational
	logic signed [VW-1:0]       raw0_e, raw1_e, raw2_e;
	logic signed [PW-1:0]       ylin, yrnd;
	logic signed [VW-1:0]       vs [3];
	logic signed [FIELD_W-1:0]  fld_c [3];
	logic signed [VW-1:0]       gate_w;
	logic [2:0]                 in_gate;
	logic                       gated;
	logic                       mode_c;
	logic                       hit;
	logic signed [EB-1:0]       sat_c [3];
	logic signed [EB:0]         sum_c [3];
	logic signed [EB:0]         mid_c [3];
	logic signed [EB:0]         span_c [3];
	logic                       ge;
	logic [DIV_STEPS-1:0]       quo_next;
	logic [GAIN_W-1:0]          gain_val;
	logic                       out_free;
	logic                       out_load;
	logic                       div_last;
	logic                       take;

	assign raw0_e = VW'(sample.raw_first_axis);
	assign raw1_e = VW'(sample.raw_second_axis);
	assign raw2_e = VW'(sample.raw_third_axis);

	// y rounding and corrected fields
	always_comb begin
		ylin  = prod_q - Y_BIAS_W;
		yrnd  = ylin + HALF_W;
		vs[0] = v_q[0];
		vs[1] = VW'(yrnd >>> SH);
		vs[2] = v_q[2];
		for (int i = 0; i < 3; i++) begin
			fld_c[i] = FIELD_W'(WW'(vs[i]) - (WW'(off_q[i]) <<< F));
		end
	end

	// gate, clamp and completion check
	always_comb begin
		gate_w = signed'(VW'({1'b0, gate_q})) <<< F;
		for (int i = 0; i < 3; i++) begin
			in_gate[i] = (v_q[i] < gate_w) && (v_q[i] > -gate_w);
			if (v_q[i] > VW'(EXT_HI)) begin
				sat_c[i] = EXT_HI;
			end else if (v_q[i] < VW'(EXT_LO)) begin
				sat_c[i] = EXT_LO;
			end else begin
				sat_c[i] = v_q[i][EB-1:0];
			end
		end
		gated  = &in_gate;
		mode_c = mode_q | start_q;
		hit    = mode_c && gated && (cnt_q == cycles_q);
	end

	// midpoints (truncated toward zero) and spans
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i]  = (EB+1)'(max_q[i]) + (EB+1)'(min_q[i]);
			mid_c[i]  = (sum_c[i] + (sum_c[i][EB] ? MID_RND : '0)) >>> (F + 1);
			span_c[i] = (EB+1)'(max_q[i]) - (EB+1)'(min_q[i]);
		end
	end

	// shared divider step
	always_comb begin
		ge       = DW'(rem_q) >= dsh_q;
		quo_next = {quo_q[DIV_STEPS-2:0], ge};
		gain_val = (zden_q || quo_next[DIV_STEPS-1]) ? GAIN_SAT : quo_next[GAIN_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (sample.valid) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_GATE;
			ST_GATE:  state_d = hit ? ST_MID : ST_FIN;
			ST_MID:   state_d = ST_DIV;
			ST_DIV:   if (div_last && sel_q) state_d = ST_FIN;
			ST_FIN:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		out_free     = !res_valid_q || result.ready;
		sample.ready = (state_q == ST_IDLE);
		take         = sample.valid && (state_q == ST_IDLE);
		out_load     = (state_q == ST_FIN) && out_free;
		div_last     = (state_q == ST_DIV) && (step_q == DIV_LAST);
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_q <= CAL_CYCLES_RST;
			gate_q   <= GATE_LIMIT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_CALIBRATION_CYCLES) cycles_q <= cfg.data;
			if (cfg.index == REG_GATE_LIMIT) gate_q <= cfg.data[GATE_W-1:0];
		end
	end

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				max_q[i] <= MAX_RST;
				min_q[i] <= MIN_RST;
				off_q[i] <= OFFSET_RST;
			end
			gain_y_q <= GAIN_Y_RST;
			gain_z_q <= GAIN_Z_RST;
			cnt_q    <= '0;
			mode_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (state_q == ST_GATE) begin
				mode_q <= mode_c && !hit;
				done_q <= hit;
				if (mode_c) begin
					cnt_q <= hit ? CYCLES_W'(1) : cnt_q + CYCLES_W'(1);
					if (gated) begin
						for (int i = 0; i < 3; i++) begin
							if (sat_c[i] > max_q[i]) max_q[i] <= sat_c[i];
							if (sat_c[i] < min_q[i]) min_q[i] <= sat_c[i];
						end
					end
				end
			end
			if (state_q == ST_MID) begin
				for (int i = 0; i < 3; i++) begin
					off_q[i] <= mid_c[i][OFFSET_W-1:0];
				end
			end
			if (div_last) begin
				if (sel_q) begin
					gain_z_q <= gain_val;
				end else begin
					gain_y_q <= gain_val;
				end
			end
		end
	end

	// datapath and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			step_q <= '0;
		end else begin
			if (state_q == ST_MID) begin
				sel_q  <= 1'b0;
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				if (div_last) begin
					sel_q  <= 1'b1;
					step_q <= '0;
				end else begin
					step_q <= step_q + DIV_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_q  <= PW'(raw0_e) * Y_SCALE_W;
			v_q[0]  <= (raw1_e - X_BIAS_W) <<< F;
			v_q[2]  <= (-raw2_e) <<< F;
			start_q <= sample.start_calibration;
		end
		if (state_q == ST_SCALE) begin
			v_q[1] <= vs[1];
			for (int i = 0; i < 3; i++) begin
				fld_q[i] <= fld_c[i];
			end
		end
		unique case (state_q)
			ST_MID: begin
				span_x_q <= span_c[0];
				span_z_q <= span_c[2];
				rem_q    <= {span_c[0][EB-1:0], {GAIN_SHIFT{1'b0}}};
				dsh_q    <= {span_c[1][EB-1:0], {GAIN_W{1'b0}}};
				zden_q   <= span_c[1][EB] || (span_c[1] == '0);
				quo_q    <= '0;
			end
			ST_DIV: begin
				if (div_last) begin
					rem_q  <= {span_x_q[EB-1:0], {GAIN_SHIFT{1'b0}}};
					dsh_q  <= {span_z_q[EB-1:0], {GAIN_W{1'b0}}};
					zden_q <= span_z_q[EB] || (span_z_q == '0);
					quo_q  <= '0;
				end else begin
					if (ge) rem_q <= rem_q - dsh_q[RW-1:0];
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_next;
				end
			end
			ST_IDLE, ST_SCALE, ST_GATE, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < 3; i++) begin
				res_fld_q[i] <= fld_q[i];
				res_off_q[i] <= off_q[i];
			end
			res_gain_y_q <= gain_y_q;
			res_gain_z_q <= gain_z_q;
			res_cal_q    <= mode_q;
			res_done_q   <= done_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.field_x          = res_fld_q[0];
	assign result.field_y          = res_fld_q[1];
	assign result.field_z          = res_fld_q[2];
	assign result.offset_x_out     = res_off_q[0];
	assign result.offset_y_out     = res_off_q[1];
	assign result.offset_z_out     = res_off_q[2];
	assign result.gain_y_out       = res_gain_y_q;
	assign result.gain_z_out       = res_gain_z_q;
	assign result.calibrating      = res_cal_q;
	assign result.calibration_done = res_done_q;

endmodule

### rtl/core/mhic_checker.sv
// ----------------------------------------------------------------------------
// mhic_checker
// port-level checks of the hard-iron calibrator, bound to the top level
// ----------------------------------------------------------------------------
module mhic_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         sample_valid,
	input logic                         sample_ready,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [mhic_pkg::FIELD_W-1:0] field_x,
	input logic [mhic_pkg::GAIN_W-1:0]  gain_y_out,
	input logic                         calibrating,
	input logic                         calibration_done
);
	import mhic_pkg::*;

	// one sample in flight: no new beat right after one is taken
	busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while previous one still in progress");

	// a completing beat has always left calibration mode
	done_ends_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(calibration_done && calibrating))
		else $error("calibration reported done while still calibrating");

	// no result appears on the cycle right after an accepted sample
	result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !result_valid |=> !result_valid)
		else $error("result appeared too early");

	// stalled result beat holds
	result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(field_x)
		&& $stable(gain_y_out))
		else $error("stalled result beat changed");

endmodule

bind magnetometer_hard_iron_calibrator mhic_checker u_mhic_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample.valid),
	.sample_ready     (sample.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.field_x          (result.field_x),
	.gain_y_out       (result.gain_y_out),
	.calibrating      (result.calibrating),
	.calibration_done (result.calibration_done)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the magnetometer hard-iron calibrator: a queue-fed
// driver sends raw sample beats in random bursts, a bit-true predictor works
// out every result beat, and a monitor compares each one field by field while
// the receiver stalls on its own changing pattern
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mhic_pkg::*;

	localparam int     FRAC         = 8;
	localparam longint FRAC_ONE     = 256;
	localparam longint Y_SCALE      = 68592;
	localparam longint Y_BIAS       = 102888;
	localparam longint RAW_X_BIAS   = 8;
	localparam longint EXT_HI       = 131071;
	localparam longint EXT_LO       = -131072;
	localparam int     RANDOM_ITEMS = 1850;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	typedef struct {
		logic signed [RAW_W-1:0] raw_first;
		logic signed [RAW_W-1:0] raw_second;
		logic signed [RAW_W-1:0] raw_third;
		logic                    start;
	} mag_sample_t;

	typedef struct {
		logic signed [FIELD_W-1:0]  field_x;
		logic signed [FIELD_W-1:0]  field_y;
		logic signed [FIELD_W-1:0]  field_z;
		logic signed [OFFSET_W-1:0] offset_x;
		logic signed [OFFSET_W-1:0] offset_y;
		logic signed [OFFSET_W-1:0] offset_z;
		logic [GAIN_W-1:0]          gain_y;
		logic [GAIN_W-1:0]          gain_z;
		logic                       calibrating;
		logic                       done;
	} mag_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mhic_sample_if sample_ch ();
	mhic_result_if result_ch ();
	mhic_cfg_if    cfg_ch ();

	magnetometer_hard_iron_calibrator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #2ns clk = ~clk;

	// calibrator state as predicted
	longint              axis_max [3];
	longint              axis_min [3];
	longint              axis_offset [3];
	logic [GAIN_W-1:0]   gain_y;
	logic [GAIN_W-1:0]   gain_z;
	logic [CYCLES_W-1:0] sample_count;
	logic [CYCLES_W-1:0] cal_cycles_reg;
	logic [GATE_W-1:0]   gate_limit_reg;
	bit                  calibrating_now;

	mag_sample_t samples_to_send [$];
	mag_result_t expected_results [$];
	mag_sample_t in_flight;
	mag_result_t want;
	int          items_queued = 0;
	int          items_accepted = 0;
	int          error_count = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	bit          drain_hold = 1'b0;
	logic [7:0]  stall_phase = '0;
	int          stall_mode = 0;

	task automatic reset_model();
		for (int i = 0; i < 3; i++) begin
			axis_max[i] = -EXTREME_RST * FRAC_ONE;
			axis_min[i] = EXTREME_RST * FRAC_ONE;
			axis_offset[i] = -1;
		end
		gain_y = GAIN_Y_RST;
		gain_z = GAIN_Z_RST;
		sample_count = '0;
		cal_cycles_reg = CAL_CYCLES_RST;
		gate_limit_reg = GATE_LIMIT_RST;
		calibrating_now = 1'b0;
	endtask

	function automatic logic [GAIN_W-1:0] span_gain(input longint num, input longint den);
		longint q;
		if (den <= 0)
			return GAIN_SAT;
		q = num * 256 / den;
		if (q < 0)
			q = 0;
		return (q > 65535) ? GAIN_SAT : q[GAIN_W-1:0];
	endfunction

	function automatic mag_result_t correct_sample(input mag_sample_t s);
		mag_result_t r;
		longint      v [3];
		longint      field [3];
		longint      span [3];
		longint      gate;
		longint      clipped;
		longint      mid;
		bit          in_gate;
		bit          done;
		done = 1'b0;
		v[0] = (longint'(s.raw_second) - RAW_X_BIAS) * FRAC_ONE;
		v[1] = (Y_SCALE * longint'(s.raw_first) - Y_BIAS + FRAC_ONE / 2) >>> FRAC;
		v[2] = -longint'(s.raw_third) * FRAC_ONE;
		for (int i = 0; i < 3; i++)
			field[i] = v[i] - axis_offset[i] * FRAC_ONE;
		if (s.start)
			calibrating_now = 1'b1;
		if (calibrating_now) begin
			gate = longint'(gate_limit_reg) * FRAC_ONE;
			in_gate = 1'b1;
			for (int i = 0; i < 3; i++)
				if (v[i] >= gate || v[i] <= -gate)
					in_gate = 1'b0;
			if (in_gate) begin
				for (int i = 0; i < 3; i++) begin
					clipped = (v[i] > EXT_HI) ? EXT_HI : ((v[i] < EXT_LO) ? EXT_LO : v[i]);
					if (clipped > axis_max[i])
						axis_max[i] = clipped;
					if (clipped < axis_min[i])
						axis_min[i] = clipped;
				end
				if (sample_count == cal_cycles_reg) begin
					for (int i = 0; i < 3; i++) begin
						mid = (axis_max[i] + axis_min[i]) / (2 * FRAC_ONE);
						axis_offset[i] = (mid > 511) ? 511 : ((mid < -512) ? -512 : mid);
						span[i] = axis_max[i] - axis_min[i];
					end
					gain_y = span_gain(span[0], span[1]);
					gain_z = span_gain(span[0], span[2]);
					sample_count = '0;
					calibrating_now = 1'b0;
					done = 1'b1;
				end
			end
			sample_count = sample_count + CYCLES_W'(1);
		end
		r.field_x = field[0][FIELD_W-1:0];
		r.field_y = field[1][FIELD_W-1:0];
		r.field_z = field[2][FIELD_W-1:0];
		r.offset_x = axis_offset[0][OFFSET_W-1:0];
		r.offset_y = axis_offset[1][OFFSET_W-1:0];
		r.offset_z = axis_offset[2][OFFSET_W-1:0];
		r.gain_y = gain_y;
		r.gain_z = gain_z;
		r.calibrating = calibrating_now;
		r.done = done;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < 50)
			$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	task automatic check_field(input string label, input logic [FIELD_W-1:0] got,
			input logic [FIELD_W-1:0] wanted);
		if (got !== wanted)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", label, got, wanted));
	endtask

	function automatic logic signed [RAW_W-1:0] clamp_raw(input int v);
		int c;
		c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
		return c[RAW_W-1:0];
	endfunction

	function automatic int spread(input int rng);
		return int'($urandom_range(0, 2 * rng)) - rng;
	endfunction

	task automatic queue_sample(input int r1, input int r2, input int r3, input bit start);
		mag_sample_t s;
		s.raw_first = clamp_raw(r1);
		s.raw_second = clamp_raw(r2);
		s.raw_third = clamp_raw(r3);
		s.start = start;
		samples_to_send.push_back(s);
		items_queued++;
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_CALIBRATION_CYCLES: cal_cycles_reg = value;
			REG_GATE_LIMIT: gate_limit_reg = value[GATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_results.push_back(correct_sample(in_flight));
				items_accepted++;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_ch.valid <= 1'b0;
				end else if (drain_hold) begin
					if (expected_results.size() == 0)
						drain_hold = 1'b0;
					sample_ch.valid <= 1'b0;
				end else if (samples_to_send.size() > 0) begin
					in_flight = samples_to_send.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.raw_first_axis <= in_flight.raw_first;
					sample_ch.raw_second_axis <= in_flight.raw_second;
					sample_ch.raw_third_axis <= in_flight.raw_third;
					sample_ch.start_calibration <= in_flight.start;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
						if ($urandom_range(0, 15) == 0)
							gap_left = $urandom_range(20, 40);
						drain_hold = ($urandom_range(0, 19) == 0);
					end
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_results.pop_front();
					check_field("field_x", result_ch.field_x, want.field_x);
					check_field("field_y", result_ch.field_y, want.field_y);
					check_field("field_z", result_ch.field_z, want.field_z);
					check_field("offset_x_out", FIELD_W'(result_ch.offset_x_out),
						FIELD_W'(want.offset_x));
					check_field("offset_y_out", FIELD_W'(result_ch.offset_y_out),
						FIELD_W'(want.offset_y));
					check_field("offset_z_out", FIELD_W'(result_ch.offset_z_out),
						FIELD_W'(want.offset_z));
					check_field("gain_y_out", FIELD_W'(result_ch.gain_y_out),
						FIELD_W'(want.gain_y));
					check_field("gain_z_out", FIELD_W'(result_ch.gain_z_out),
						FIELD_W'(want.gain_z));
					check_field("calibrating", FIELD_W'(result_ch.calibrating),
						FIELD_W'(want.calibrating));
					check_field("calibration_done", FIELD_W'(result_ch.calibration_done),
						FIELD_W'(want.done));
				end
			end
			stall_phase <= stall_phase + 8'd1;
			if (stall_phase == '0)
				stall_mode = $urandom_range(0, 4);
			case (stall_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ($urandom_range(0, 3) == 0);
				3: result_ch.ready <= (stall_phase[2:0] != 3'd0);
				default: result_ch.ready <= (stall_phase[4:0] == 5'd0);
			endcase
		end
	end

	initial begin
		int                    random_items;
		int                    gate_val;
		int                    rng;
		int                    n;
		int                    kind;
		bit                    start_now;
		logic [CFG_DATA_W-1:0] gate_data;
		logic [CFG_DATA_W-1:0] cycles_data;
		random_items = 0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_first_axis = '0;
		sample_ch.raw_second_axis = '0;
		sample_ch.raw_third_axis = '0;
		sample_ch.start_calibration = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_CALIBRATION_CYCLES;
		cfg_ch.data = '0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// first gated sample completes at once, every span zero
		write_register(REG_CALIBRATION_CYCLES, 16'd0);
		queue_sample(10, 20, -5, 1'b1);
		queue_sample(-32768, 32767, -32768, 1'b0);
		queue_sample(32767, -32768, 32767, 1'b0);
		queue_sample(0, 0, 0, 1'b0);
		wait_idle();

		// back-to-back completions: zero y span, tiny y span, ordinary gains
		write_register(REG_CALIBRATION_CYCLES, 16'd1);
		queue_sample(10, 300, -5, 1'b1);
		queue_sample(11, -200, -5, 1'b1);
		queue_sample(-150, 20, -300, 1'b1);
		queue_sample(1000, 20, -5, 1'b1);
		queue_sample(10, 20, -5, 1'b0);
		wait_idle();

		// zero gate
		write_register(REG_GATE_LIMIT, 16'd0);
		write_register(REG_CALIBRATION_CYCLES, sample_count);
		queue_sample(1, 8, 0, 1'b1);
		queue_sample(2, 9, 1, 1'b0);
		wait_idle();

		// widest gate, full-scale samples clip the extremes
		write_register(REG_GATE_LIMIT, 16'hFFFF);
		write_register(REG_CALIBRATION_CYCLES, sample_count);
		queue_sample(-31000, 32767, -32766, 1'b1);
		queue_sample(31000, -32768, 32767, 1'b1);
		queue_sample(-32768, 0, -32768, 1'b1);
		wait_idle();

		// unmapped indexes, narrowest nonzero gate, longest count
		write_register(REG_UNMAPPED_LO, 16'hFFFF);
		write_register(REG_UNMAPPED_HI, 16'h0000);
		write_register(REG_GATE_LIMIT, 16'd1);
		write_register(REG_CALIBRATION_CYCLES, 16'hFFFF);
		queue_sample(1, 8, 0, 1'b1);
		queue_sample(2, 8, 0, 1'b0);
		queue_sample(0, 8, 0, 1'b0);
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_register(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
					16'($urandom));
			case ($urandom_range(0, 9))
				0: gate_val = 0;
				1: gate_val = 1;
				2: gate_val = 32767;
				3: gate_val = $urandom_range(1, 32767);
				default: gate_val = $urandom_range(2, 600);
			endcase
			gate_data = {1'($urandom_range(0, 1)), 15'(gate_val)};
			case ($urandom_range(0, 9))
				0: cycles_data = 16'hFFFF;
				1: cycles_data = 16'($urandom);
				default: cycles_data = sample_count + 16'($urandom_range(0, 30));
			endcase
			if ($urandom_range(0, 1) != 0) begin
				write_register(REG_GATE_LIMIT, gate_data);
				write_register(REG_CALIBRATION_CYCLES, cycles_data);
			end else begin
				write_register(REG_CALIBRATION_CYCLES, cycles_data);
				write_register(REG_GATE_LIMIT, gate_data);
			end
			rng = (gate_val > 0) ? gate_val - 1 : 0;
			n = $urandom_range(10, 60);
			for (int k = 0; k < n; k++) begin
				kind = $urandom_range(0, 19);
				start_now = (k == 0) ? ($urandom_range(0, 7) != 0) : (kind == 19);
				if (kind < 16)
					queue_sample(1 + spread(rng * 19 / 20), int'(RAW_X_BIAS) + spread(rng),
						spread(rng), start_now);
				else
					queue_sample(spread(32768), spread(32768), spread(32768), start_now);
			end
			random_items += n;
			wait_idle();
		end

		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
